### sv/gmap_pkg.sv
// shared types, constants and a helper function for the gradient map
`default_nettype none

package gmap_pkg;

   // field and register widths
   localparam int LUM_BITS       = 8;
   localparam int COLOR_BITS     = 24;
   localparam int CHAN_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STOP_COUNT     = 4;
   localparam int T_BITS         = 7;
   localparam int PROD_BITS      = 15;
   localparam int RSP_BITS       = 16;

   // packed output channel widths
   localparam int RED_BITS   = 5;
   localparam int GREEN_BITS = 6;
   localparam int BLUE_BITS  = 5;

   // segment boundaries on the luminance axis
   localparam logic [LUM_BITS-1:0] SEG_SPAN   = 8'd85;
   localparam logic [LUM_BITS-1:0] SEG_SPAN_2 = 8'd170;

   // segment indexes, also the lower stop of each segment
   localparam logic [1:0] SEG_LOW  = 2'd0;
   localparam logic [1:0] SEG_MID  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;

   // floor(m / 85) == (m * SEG_RECIP) >> SEG_RECIP_SHIFT for m <= 255 * 85
   localparam logic [15:0] SEG_RECIP       = 16'd49345;
   localparam int          SEG_RECIP_SHIFT = 22;
   localparam int          SCALE_BITS      = 31;

   // pipeline advance strobes shared by the channel datapaths
   typedef struct packed {
      logic ld_mult;
      logic ld_scale;
   } gmap_adv_type;

   // (c * maxv + 127) / 255, with the divide done as (x + (x >> 8) + 1) >> 8
   function automatic logic [CHAN_BITS-1:0] round_chan(input logic [CHAN_BITS-1:0] c,
                                                      input logic [5:0] maxv);
      logic [15:0] x;
      logic [15:0] y;
      x = ({8'b0, c} * {10'b0, maxv}) + 16'd127;
      y = x + {8'b0, x[15:8]} + 16'd1;
      return y[15:8];
   endfunction

endpackage

`default_nettype wire

### sv/gmap_stop_mem.sv
// stop color memory: one write port, two registered read ports
`default_nettype none

module gmap_stop_mem
   import gmap_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COLOR_BITS-1:0]     csr_wdata,
   input  wire logic                      rd_en,
   input  wire logic [1:0]                rd_seg,
   output logic      [COLOR_BITS-1:0]     lo_color,
   output logic      [COLOR_BITS-1:0]     hi_color
);

   logic [COLOR_BITS-1:0] mem [STOP_COUNT];
   logic [STOP_COUNT-1:0] valid_ff;
   logic [STOP_COUNT-1:0] valid_in;
   logic [1:0]            hi_addr;
   logic [COLOR_BITS-1:0] lo_ff;
   logic [COLOR_BITS-1:0] hi_ff;

   assign hi_addr  = rd_seg + 2'd1;
   assign lo_color = lo_ff;
   assign hi_color = hi_ff;

   // entries never written read as zero
   always_comb begin
      valid_in = valid_ff;
      if (csr_wr_en) begin
         valid_in[csr_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (csr_wr_en) begin
         mem[csr_index] <= csr_wdata;
      end
   end

   // two read ports, data held while the pipeline stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         lo_ff <= valid_ff[rd_seg]  ? mem[rd_seg]  : '0;
         hi_ff <= valid_ff[hi_addr] ? mem[hi_addr] : '0;
      end
   end

   // reset leaves every stop reading as zero
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> valid_ff == '0)
      else $error("stop valid bits not cleared by reset");

   // a write marks its entry valid
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> valid_ff[$past(csr_index)])
      else $error("written stop entry not marked valid");

   // an unwritten lower stop reads as zero
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !valid_ff[rd_seg]) |=> lo_ff == '0)
      else $error("unwritten stop entry read as nonzero");

endmodule

`default_nettype wire

### sv/gmap_channel.sv
// one color channel: blend between two stops and round to the output width
`default_nettype none

module gmap_channel
   import gmap_pkg::*;
#(
   parameter int OUT_BITS = RED_BITS
) (
   input  wire logic                 clock,
   input  wire gmap_adv_type         adv,
   input  wire logic [CHAN_BITS-1:0] lo_chan,
   input  wire logic [CHAN_BITS-1:0] hi_chan,
   input  wire logic [T_BITS-1:0]    t,
   output logic      [OUT_BITS-1:0]  chan_out
);

   localparam logic [5:0] MAXV = 6'((1 << OUT_BITS) - 1);

   logic                 neg_in;
   logic [CHAN_BITS-1:0] mag_in;
   logic [PROD_BITS-1:0] prod_in;
   logic [PROD_BITS-1:0] prod_ff;
   logic                 neg_ff;
   logic [CHAN_BITS-1:0] base_ff;
   logic [SCALE_BITS-1:0] scaled;
   logic [CHAN_BITS-1:0] quot_in;
   logic [CHAN_BITS-1:0] quot_ff;
   logic                 neg2_ff;
   logic [CHAN_BITS-1:0] base2_ff;
   logic [CHAN_BITS-1:0] blended;
   logic [CHAN_BITS-1:0] rounded;

   // magnitude of the stop difference times the segment offset
   assign neg_in  = hi_chan < lo_chan;
   assign mag_in  = neg_in ? (lo_chan - hi_chan) : (hi_chan - lo_chan);
   assign prod_in = {7'b0, mag_in} * {8'b0, t};

   always_ff @(posedge clock) begin
      if (adv.ld_mult) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
         base_ff <= lo_chan;
      end
   end

   // divide by the segment span through a reciprocal
   assign scaled  = {16'b0, prod_ff} * {15'b0, SEG_RECIP};
   assign quot_in = scaled[SEG_RECIP_SHIFT +: CHAN_BITS];

   always_ff @(posedge clock) begin
      if (adv.ld_scale) begin
         quot_ff  <= quot_in;
         neg2_ff  <= neg_ff;
         base2_ff <= base_ff;
      end
   end

   // truncation toward zero falls out of dividing the magnitude
   assign blended  = neg2_ff ? (base2_ff - quot_ff) : (base2_ff + quot_ff);
   assign rounded  = round_chan(blended, MAXV);
   assign chan_out = rounded[OUT_BITS-1:0];

endmodule

`default_nettype wire

### sv/four_stop_gradient_map_rgb565.sv
// top level: luminance to rgb565 through a four-stop gradient
// a request passes the stop read, product, quotient and output registers in that order
// throughput: one transaction per cycle absent rsp_ready stalls, by two stop read ports
// stalls on rsp_ready hold full stages, empty ones fill; no bubble is added by a stall
// reset clears the pipeline valids and the stop valid bits, so all stops read as zero
// configuration takes effect at once and is expected only while the pipeline is empty
`default_nettype none

module four_stop_gradient_map_rgb565
   import gmap_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [LUM_BITS-1:0]       req_luminance,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [RSP_BITS-1:0]       rsp_color_565,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COLOR_BITS-1:0]     csr_wdata
);

   logic                  v1_ff, v1_in;
   logic                  v2_ff, v2_in;
   logic                  v3_ff, v3_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rdy1, rdy2, rdy3, rdy_out;
   logic [1:0]            seg_in;
   logic [T_BITS-1:0]     t_in;
   logic [T_BITS-1:0]     t_ff;
   logic [COLOR_BITS-1:0] lo_color;
   logic [COLOR_BITS-1:0] hi_color;
   gmap_adv_type          adv;
   logic [RED_BITS-1:0]   red;
   logic [GREEN_BITS-1:0] green;
   logic [BLUE_BITS-1:0]  blue;
   logic [RSP_BITS-1:0]   color_in;
   logic [RSP_BITS-1:0]   color_ff;

   // ready chain: a stage loads when empty or when its successor moves
   assign rdy_out = !rsp_valid_ff || rsp_ready;
   assign rdy3    = !v3_ff || rdy_out;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;

   assign req_ready    = rdy1;
   assign adv.ld_mult  = rdy2;
   assign adv.ld_scale = rdy3;

   always_comb begin
      v1_in        = rdy1    ? req_valid : v1_ff;
      v2_in        = rdy2    ? v1_ff     : v2_ff;
      v3_in        = rdy3    ? v2_ff     : v3_ff;
      rsp_valid_in = rdy_out ? v3_ff     : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // segment and offset within it
   always_comb begin
      if (req_luminance <= SEG_SPAN) begin
         seg_in = SEG_LOW;
         t_in   = req_luminance[T_BITS-1:0];
      end else if (req_luminance <= SEG_SPAN_2) begin
         seg_in = SEG_MID;
         t_in   = 7'(req_luminance - SEG_SPAN);
      end else begin
         seg_in = SEG_HIGH;
         t_in   = 7'(req_luminance - SEG_SPAN_2);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t_ff <= t_in;
      end
   end

   // stop color lookup
   gmap_stop_mem u_stop_mem (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_en     (rdy1),
      .rd_seg    (seg_in),
      .lo_color  (lo_color),
      .hi_color  (hi_color)
   );

   // per-channel blend and rounding
   gmap_channel #(.OUT_BITS(RED_BITS)) u_red (
      .clock    (clock),
      .adv      (adv),
      .lo_chan  (lo_color[23:16]),
      .hi_chan  (hi_color[23:16]),
      .t        (t_ff),
      .chan_out (red)
   );

   gmap_channel #(.OUT_BITS(GREEN_BITS)) u_green (
      .clock    (clock),
      .adv      (adv),
      .lo_chan  (lo_color[15:8]),
      .hi_chan  (hi_color[15:8]),
      .t        (t_ff),
      .chan_out (green)
   );

   gmap_channel #(.OUT_BITS(BLUE_BITS)) u_blue (
      .clock    (clock),
      .adv      (adv),
      .lo_chan  (lo_color[7:0]),
      .hi_chan  (hi_color[7:0]),
      .t        (t_ff),
      .chan_out (blue)
   );

   // pack into the output register
   assign color_in = {red, green, blue};

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         color_ff <= color_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_color_565 = color_ff;

   // an accepted transaction always lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transaction lost at stage one");

   // a blocked middle stage keeps its transaction
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> v2_ff)
      else $error("stalled stage two dropped its transaction");

   // a full pipeline with a stalled output refuses new requests
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

endmodule

`default_nettype wire
